/* hdl/lsw_pkg.sv */
package lsw_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int MAC_W         = 48;
    localparam int PORT_W        = 8;
    localparam int ENTRY_W       = MAC_W + PORT_W;
    localparam int MCAST_BIT     = 40;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'h06;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam logic [7:0]  PROTO_ICMP     = 8'h01;

    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_TCP   = 2'd1;
    localparam logic [1:0] CLASS_UDP   = 2'd2;
    localparam logic [1:0] CLASS_ICMP  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

/* hdl/lsw_ram.sv */
module lsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lsw_ctrl.sv */
module lsw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lsw_pkg::t_status i_status,
    output lsw_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state;

    assign o_ready = (r_state == S_IDLE);

    // commands from state
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.rd_en  = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FIN) && i_status.out_free;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_status.fill_zero ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_status.idx_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/lsw_datapath.sv */
module lsw_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsw_pkg::t_cmd    i_cmd,
    output lsw_pkg::t_status o_status,
    input  logic [15:0]      i_ethertype,
    input  logic [7:0]       i_ip_protocol,
    input  logic [47:0]      i_src_mac,
    input  logic [47:0]      i_dst_mac,
    input  logic [7:0]       i_in_port,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_egress_port,
    output logic             o_flood,
    output logic             o_counted,
    output logic [1:0]       o_protocol_class,
    output logic [63:0]      o_class_count,
    output logic             o_learn_dropped
);

    // captured header
    logic [15:0] r_ethertype;
    logic [7:0]  r_proto;
    logic [47:0] r_src;
    logic [47:0] r_dst;
    logic [7:0]  r_port;

    // table scan state
    logic [lsw_pkg::IDX_W-1:0]  r_idx;
    logic [lsw_pkg::IDX_W-1:0]  r_rd_idx;
    logic                       r_rd_vld;
    logic [lsw_pkg::FILL_W-1:0] r_fill;
    logic                       r_src_hit;
    logic [lsw_pkg::IDX_W-1:0]  r_src_idx;
    logic                       r_dst_hit;
    logic [7:0]                 r_dst_port;

    logic [63:0] r_counts [4];

    // result register
    logic        r_valid;
    logic [7:0]  r_egress_port;
    logic        r_flood;
    logic        r_counted;
    logic [1:0]  r_class;
    logic [63:0] r_count;
    logic        r_dropped;

    logic [lsw_pkg::ENTRY_W-1:0] rdata;
    logic [47:0]                 rd_mac;
    logic [7:0]                  rd_port;
    logic                        we;
    logic [lsw_pkg::IDX_W-1:0]   waddr;
    logic                        src_uni;
    logic                        full;
    logic                        learn_ok;
    logic                        learn_new;
    logic                        ipv4;
    logic [1:0]                  pclass;
    logic [63:0]                 cnt_next;
    logic [7:0]                  fwd_port;
    logic                        fwd_flood;

    assign rd_mac  = rdata[lsw_pkg::ENTRY_W-1 -: lsw_pkg::MAC_W];
    assign rd_port = rdata[lsw_pkg::PORT_W-1:0];

    // status to controller
    always_comb begin
        o_status.fill_zero = (r_fill == '0);
        o_status.idx_last  = ({1'b0, r_idx} + 1'b1 == r_fill);
        o_status.out_free  = !r_valid || i_ready;
    end

    // learning decision
    always_comb begin
        src_uni   = !r_src[lsw_pkg::MCAST_BIT];
        full      = (r_fill == lsw_pkg::FILL_W'(lsw_pkg::TABLE_ENTRIES));
        learn_ok  = src_uni && (r_src_hit || !full);
        learn_new = src_uni && !r_src_hit && !full;
        we        = i_cmd.finish && learn_ok;
        waddr     = r_src_hit ? r_src_idx : r_fill[lsw_pkg::IDX_W-1:0];
    end

    // destination lookup after learning
    always_comb begin
        fwd_port  = '0;
        fwd_flood = 1'b1;
        if (!r_dst[lsw_pkg::MCAST_BIT]) begin
            if (r_dst == r_src && learn_ok) begin
                fwd_port  = r_port;
                fwd_flood = 1'b0;
            end else if (r_dst_hit) begin
                fwd_port  = r_dst_port;
                fwd_flood = 1'b0;
            end
        end
    end

    // protocol classification
    always_comb begin
        ipv4 = (r_ethertype == lsw_pkg::ETHERTYPE_IPV4);
        case (r_proto)
            lsw_pkg::PROTO_TCP:  pclass = lsw_pkg::CLASS_TCP;
            lsw_pkg::PROTO_UDP:  pclass = lsw_pkg::CLASS_UDP;
            lsw_pkg::PROTO_ICMP: pclass = lsw_pkg::CLASS_ICMP;
            default:             pclass = lsw_pkg::CLASS_OTHER;
        endcase
        cnt_next = r_counts[pclass] + 64'd1;
    end

    lsw_ram #(
        .WIDTH (lsw_pkg::ENTRY_W),
        .DEPTH (lsw_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_src, r_port}),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // header capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ethertype <= i_ethertype;
            r_proto     <= i_ip_protocol;
            r_src       <= i_src_mac;
            r_dst       <= i_dst_mac;
            r_port      <= i_in_port;
        end
        r_rd_idx <= r_idx;
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.rd_en) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.load) begin
            r_src_hit <= 1'b0;
            r_dst_hit <= 1'b0;
        end else if (r_rd_vld) begin
            if (rd_mac == r_src) begin
                r_src_hit <= 1'b1;
                r_src_idx <= r_rd_idx;
            end
            if (rd_mac == r_dst) begin
                r_dst_hit  <= 1'b1;
                r_dst_port <= rd_port;
            end
        end
        if (i_cmd.finish) begin
            r_egress_port <= fwd_port;
            r_flood       <= fwd_flood;
            r_counted     <= ipv4;
            r_class       <= ipv4 ? pclass : lsw_pkg::CLASS_OTHER;
            r_count       <= ipv4 ? cnt_next : 64'd0;
            r_dropped     <= src_uni && !r_src_hit && full;
        end
    end

    // control state: fill count, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_fill   <= '0;
            r_valid  <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.finish && learn_new) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.finish && ipv4) begin
                r_counts[pclass] <= cnt_next;
            end
            if (i_cmd.finish) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_egress_port    = r_egress_port;
    assign o_flood          = r_flood;
    assign o_counted        = r_counted;
    assign o_protocol_class = r_class;
    assign o_class_count    = r_count;
    assign o_learn_dropped  = r_dropped;

endmodule

/* hdl/learning_switch_with_protocol_counts_core.sv */
// channel  | valid   | ready   | payload
// input    | i_valid | o_ready | i_ethertype i_ip_protocol i_src_mac i_dst_mac i_in_port
// output   | o_valid | i_ready | o_egress_port o_flood o_counted o_protocol_class
//          |         |         | o_class_count o_learn_dropped
//
// one header per transaction; the table is scanned one entry per cycle through
// the single read port of the table ram, so a header's scan covers fill entries
// (none while the table is empty), fill being the number of learned entries
// reset clears the fill count and the four protocol counters at once
// a stalled output holds the finished result; the next header is taken once
// the result moves into the output register

module learning_switch_with_protocol_counts_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_ethertype,
    input  logic [7:0]  i_ip_protocol,
    input  logic [47:0] i_src_mac,
    input  logic [47:0] i_dst_mac,
    input  logic [7:0]  i_in_port,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_egress_port,
    output logic        o_flood,
    output logic        o_counted,
    output logic [1:0]  o_protocol_class,
    output logic [63:0] o_class_count,
    output logic        o_learn_dropped
);

    lsw_pkg::t_cmd    cmd;
    lsw_pkg::t_status status;

    lsw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lsw_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_ethertype      (i_ethertype),
        .i_ip_protocol    (i_ip_protocol),
        .i_src_mac        (i_src_mac),
        .i_dst_mac        (i_dst_mac),
        .i_in_port        (i_in_port),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_egress_port    (o_egress_port),
        .o_flood          (o_flood),
        .o_counted        (o_counted),
        .o_protocol_class (o_protocol_class),
        .o_class_count    (o_class_count),
        .o_learn_dropped  (o_learn_dropped)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int NUM_RANDOM  = 1750;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  ip_protocol;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [7:0]  in_port;
    } t_header;

    typedef struct packed {
        logic [7:0]  egress_port;
        logic        flood;
        logic        counted;
        logic [1:0]  protocol_class;
        logic [63:0] class_count;
        logic        learn_dropped;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_ethertype;
    logic [7:0]  i_ip_protocol;
    logic [47:0] i_src_mac;
    logic [47:0] i_dst_mac;
    logic [7:0]  i_in_port;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_egress_port;
    logic        o_flood;
    logic        o_counted;
    logic [1:0]  o_protocol_class;
    logic [63:0] o_class_count;
    logic        o_learn_dropped;

    learning_switch_with_protocol_counts_core u_dut (.*);

    // switch shadow state
    logic        fwd_valid [lsw_pkg::TABLE_ENTRIES];
    logic [47:0] fwd_mac   [lsw_pkg::TABLE_ENTRIES];
    logic [7:0]  fwd_port  [lsw_pkg::TABLE_ENTRIES];
    logic [63:0] class_tally [4];

    t_header  header_queue [$];
    t_verdict verdict_queue [$];
    logic [47:0] mac_pool [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  hold_left;
    int  mismatches;
    int  cycle_count;

    always #5 i_clk = ~i_clk;

    // forwarding decision with learning and protocol counting
    function automatic t_verdict forward_header(t_header h);
        t_verdict v;
        int hit;
        int slot;
        v = '0;
        if (h.ethertype == lsw_pkg::ETHERTYPE_IPV4) begin
            if (h.ip_protocol == lsw_pkg::PROTO_TCP) v.protocol_class = lsw_pkg::CLASS_TCP;
            else if (h.ip_protocol == lsw_pkg::PROTO_UDP) v.protocol_class = lsw_pkg::CLASS_UDP;
            else if (h.ip_protocol == lsw_pkg::PROTO_ICMP) v.protocol_class = lsw_pkg::CLASS_ICMP;
            else v.protocol_class = lsw_pkg::CLASS_OTHER;
            class_tally[v.protocol_class] = class_tally[v.protocol_class] + 64'd1;
            v.class_count = class_tally[v.protocol_class];
            v.counted = 1'b1;
        end
        if (!h.src_mac[lsw_pkg::MCAST_BIT]) begin
            hit = -1;
            slot = -1;
            for (int i = 0; i < lsw_pkg::TABLE_ENTRIES; i++) begin
                if (fwd_valid[i] && fwd_mac[i] == h.src_mac && hit < 0) hit = i;
                if (!fwd_valid[i] && slot < 0) slot = i;
            end
            if (hit >= 0) begin
                fwd_port[hit] = h.in_port;
            end else if (slot >= 0) begin
                fwd_valid[slot] = 1'b1;
                fwd_mac[slot] = h.src_mac;
                fwd_port[slot] = h.in_port;
            end else begin
                v.learn_dropped = 1'b1;
            end
        end
        v.flood = 1'b1;
        if (!h.dst_mac[lsw_pkg::MCAST_BIT]) begin
            for (int i = 0; i < lsw_pkg::TABLE_ENTRIES; i++) begin
                if (fwd_valid[i] && fwd_mac[i] == h.dst_mac && v.flood) begin
                    v.flood = 1'b0;
                    v.egress_port = fwd_port[i];
                end
            end
        end
        return v;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom_range(0, 16'hffff)), 32'($urandom())};
    endfunction

    // mostly known addresses so lookups hit, some fresh and multicast
    function automatic logic [47:0] pick_mac();
        logic [47:0] m;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && mac_pool.size() > 0) begin
            m = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
        end else begin
            m = rand_mac();
            if (r < 90) begin
                m[lsw_pkg::MCAST_BIT] = 1'b0;
                if (mac_pool.size() < 200) mac_pool.push_back(m);
            end
        end
        return m;
    endfunction

    function automatic t_header rand_header();
        t_header h;
        int r;
        h.src_mac = pick_mac();
        h.dst_mac = pick_mac();
        h.in_port = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        h.ethertype = (r < 7) ? lsw_pkg::ETHERTYPE_IPV4 : 16'($urandom_range(0, 16'hffff));
        r = $urandom_range(0, 4);
        case (r)
            0: h.ip_protocol = lsw_pkg::PROTO_TCP;
            1: h.ip_protocol = lsw_pkg::PROTO_UDP;
            2: h.ip_protocol = lsw_pkg::PROTO_ICMP;
            default: h.ip_protocol = 8'($urandom_range(0, 255));
        endcase
        return h;
    endfunction

    task automatic add_header(logic [15:0] et, logic [7:0] pr, logic [47:0] sm,
                              logic [47:0] dm, logic [7:0] pt);
        header_queue.push_back({et, pr, sm, dm, pt});
    endtask

    task automatic wait_drained();
        while (header_queue.size() > 0 || i_valid || verdict_queue.size() > 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (header_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_header h;
                h = header_queue.pop_front();
                verdict_queue.push_back(forward_header(h));
                i_valid <= 1'b1;
                i_ethertype <= h.ethertype;
                i_ip_protocol <= h.ip_protocol;
                i_src_mac <= h.src_mac;
                i_dst_mac <= h.dst_mac;
                i_in_port <= h.in_port;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (recv_hold && hold_left == 0) hold_left <= HOLD_CYCLES;
        else if (hold_left > 0) hold_left <= hold_left - 1;
        if (!i_rst_n || recv_hold || hold_left > 1) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_verdict got;
            t_verdict exp;
            got = {o_egress_port, o_flood, o_counted, o_protocol_class,
                   o_class_count, o_learn_dropped};
            if (verdict_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", got);
            end else begin
                exp = verdict_queue.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [47:0] m;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_ethertype = '0;
        i_ip_protocol = '0;
        i_src_mac = '0;
        i_dst_mac = '0;
        i_in_port = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        hold_left = 0;
        mismatches = 0;
        cycle_count = 0;
        foreach (fwd_valid[i]) fwd_valid[i] = 1'b0;
        foreach (class_tally[i]) class_tally[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every class, extremes, multicast, miss, refresh
        add_header(lsw_pkg::ETHERTYPE_IPV4, lsw_pkg::PROTO_TCP, 48'h0000_0000_0000,
                   48'h0000_0000_0000, 8'd0);
        add_header(lsw_pkg::ETHERTYPE_IPV4, lsw_pkg::PROTO_UDP, 48'hfeff_ffff_ffff,
                   48'h0000_0000_0000, 8'd255);
        add_header(lsw_pkg::ETHERTYPE_IPV4, lsw_pkg::PROTO_ICMP, 48'hffff_ffff_ffff,
                   48'hfeff_ffff_ffff, 8'd7);
        add_header(lsw_pkg::ETHERTYPE_IPV4, 8'hff, 48'h0000_0000_0000,
                   48'hffff_ffff_ffff, 8'd9);
        add_header(lsw_pkg::ETHERTYPE_IPV4, 8'h00, 48'h0000_0000_0000,
                   48'h0000_0000_0000, 8'd200);
        add_header(16'h0008, lsw_pkg::PROTO_TCP, 48'h0100_0000_0000, 48'h1234_5678_9abc, 8'd3);
        add_header(16'hffff, lsw_pkg::PROTO_UDP, 48'h1234_5678_9abc, 48'h1234_5678_9abc, 8'h5a);
        add_header(16'h0000, 8'hff, 48'haaaa_aaaa_aaaa, 48'h0000_0000_0000, 8'ha5);
        add_header(16'h0801, lsw_pkg::PROTO_ICMP, 48'h5555_5555_5555, 48'h5555_5555_5555, 8'h81);
        add_header(lsw_pkg::ETHERTYPE_IPV4, 8'h07, 48'h0200_0000_0001,
                   48'haaaa_aaaa_aaaa, 8'd1);
        add_header(lsw_pkg::ETHERTYPE_IPV4, 8'h10, 48'h0300_0000_0001,
                   48'h0200_0000_0001, 8'd2);
        add_header(lsw_pkg::ETHERTYPE_IPV4, 8'h12, 48'hfeff_ffff_ffff,
                   48'hfeff_ffff_ffff, 8'd44);
        wait_drained();

        // long receiver hold while the sender keeps offering
        for (int i = 0; i < 40; i++) header_queue.push_back(rand_header());
        recv_hold = 1'b1;
        wait (hold_left > 0);
        recv_hold = 1'b0;
        wait_drained();

        // random traffic across idling phases
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int i = 0; i < NUM_RANDOM / 8; i++) header_queue.push_back(rand_header());
            wait_drained();
        end

        // fill the table past capacity with fresh sources, then keep probing
        send_idle_pct = 10;
        recv_stall_pct = 10;
        for (int i = 0; i < lsw_pkg::TABLE_ENTRIES + 40; i++) begin
            m = rand_mac();
            m[lsw_pkg::MCAST_BIT] = 1'b0;
            mac_pool.push_back(m);
            add_header(lsw_pkg::ETHERTYPE_IPV4, 8'($urandom_range(0, 255)), m,
                       mac_pool[$urandom_range(0, mac_pool.size() - 1)],
                       8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < 3 * NUM_RANDOM / 8; i++) header_queue.push_back(rand_header());
        wait_drained();

        repeat (2 * lsw_pkg::TABLE_ENTRIES + 20) @(posedge i_clk);
        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/lsw_pkg.sv
hdl/lsw_ram.sv
hdl/lsw_ctrl.sv
hdl/lsw_datapath.sv
hdl/learning_switch_with_protocol_counts_core.sv
verif/tb.sv
